### src/svn_pkg.sv
// Shared types and constants for the state vector normalizer.
package svn_pkg;

  localparam int unsigned NUM_W = 49;  // |diff| << 17 magnitude
  localparam int unsigned DEN_W = 32;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] Q_NEG_ONE = -32'sh0001_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_NORM  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_ZSCORE = 2'd1,
    MODE_MINMAX = 2'd2,
    MODE_RSVD   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_NORM_MODE    = 3'd0,
    REG_CLIP_ENABLE  = 3'd1,
    REG_CLAMP_ENABLE = 3'd2,
    REG_CLAMP_LOWER  = 3'd3,
    REG_CLAMP_UPPER  = 3'd4,
    REG_MASK_ENABLE  = 3'd5,
    REG_REAL_DIM     = 3'd6,
    REG_PAD_VALUE    = 3'd7
  } reg_idx_t;

  // Sideband that travels with an element through the divider.
  typedef struct packed {
    logic              vld;
    logic [7:0]        idx;
    logic signed [31:0] v;
    logic              norm;
    mode_t             mode;
    logic              neg;
    logic              num_neg;
    logic              num_zero;
    logic              den_zero;
  } side_t;

  typedef struct packed {
    side_t              side;
    logic [NUM_W-1:0]   q;
    logic [DEN_W-1:0]   rem;
    logic [DEN_W-1:0]   den;
  } div_t;

  // One restoring division step: one quotient bit.
  function automatic div_t div_step(div_t d);
    div_t        r;
    logic [DEN_W:0] t;
    logic        ge;
    r  = d;
    t  = {d.rem, d.q[NUM_W-1]};
    ge = (t >= {1'b0, d.den});
    r.rem = ge ? DEN_W'(t - {1'b0, d.den}) : t[DEN_W-1:0];
    r.q   = {d.q[NUM_W-2:0], ge};
    return r;
  endfunction

endpackage

### src/svn_in_if.sv
// Request channel of the normalizer.
interface svn_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  elem_index;
  logic signed [31:0] elem_value;
  logic signed [31:0] first_stat;
  logic signed [31:0] second_stat;
  logic        entry_active;
  modport source (output valid, opcode, elem_index, elem_value, first_stat, second_stat,
                  entry_active, input ready);
  modport sink (input valid, opcode, elem_index, elem_value, first_stat, second_stat,
                entry_active, output ready);
endinterface

### src/svn_out_if.sv
// Result channel of the normalizer.
interface svn_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_index;
  logic signed [31:0] out_value;
  logic        error_flag;
  modport source (output valid, out_index, out_value, error_flag, input ready);
  modport sink (input valid, out_index, out_value, error_flag, output ready);
endinterface

### src/svn_cfg_if.sv
// Register write channel of the normalizer.
interface svn_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/svn_div.sv
// Pipelined unsigned divider, one quotient bit per stage, with sideband.
module svn_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  svn_pkg::div_t    d_in,
  output svn_pkg::div_t    d_out
);

  svn_pkg::div_t pipe_r [svn_pkg::NUM_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < svn_pkg::NUM_W; k++) begin
        pipe_r[k].side.vld <= 1'b0;
      end
    end else if (en) begin
      pipe_r[0] <= svn_pkg::div_step(d_in);
      for (int k = 1; k < svn_pkg::NUM_W; k++) begin
        pipe_r[k] <= svn_pkg::div_step(pipe_r[k-1]);
      end
    end
  end

  assign d_out = pipe_r[svn_pkg::NUM_W-1];

endmodule

### src/state_vector_normalizer.sv
// State vector normalizer: stats table, divider pipeline and output stage.
//
// Channels: in_ch takes requests. opcode write stores mean/stddev (or lower/upper)
// and an active bit at elem_index; opcode normalize sends one element through and
// gives exactly one result on out_ch (index, Q16.16 value, error flag).
// cfg_ch writes the mode, clip/clamp, mask, live length and pad registers; it is
// always ready and should be written only while no normalize request is in flight.
// Pipeline: the stats read and element selection land at the accept edge, then a
// register for dividend and divisor, 49 stages of the bit-per-stage divider, one
// for saturation and one for clip/clamp into the output register.
// Throughput: one request per cycle unless stalled. Stats writes land at the
// accept edge, so a normalize right after a write to the same entry reads the new data.
// Stall: the whole pipeline advances only when the output register is empty or
// taken; while the receiver holds off, in_ch.ready stays low and nothing moves.
// Reset: synchronous, active low; clears registers to their defaults and all
// valid flags. The stats table is not cleared; read an entry only after a write.
module state_vector_normalizer #(
  parameter int MAX_DIM = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  svn_in_if.sink     in_ch,
  svn_out_if.source  out_ch,
  svn_cfg_if.sink    cfg_ch
);

  localparam int DEPTH = (MAX_DIM > 256) ? 256 : MAX_DIM;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [12:0] MAX_DIM_L = 13'(MAX_DIM);

  // configuration
  svn_pkg::mode_t      norm_mode_r;
  logic                clip_en_r, clamp_en_r, mask_en_r;
  logic signed [31:0]  clamp_lo_r, clamp_hi_r, pad_r;
  logic [8:0]          live_len_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_mode_r <= svn_pkg::MODE_NONE;
      clip_en_r   <= 1'b0;
      clamp_en_r  <= 1'b0;
      clamp_lo_r  <= svn_pkg::Q_NEG_ONE;
      clamp_hi_r  <= svn_pkg::Q_ONE;
      mask_en_r   <= 1'b0;
      live_len_r  <= 9'd256;
      pad_r       <= '0;
    end else if (cfg_ch.valid) begin
      case (svn_pkg::reg_idx_t'(cfg_ch.index))
        svn_pkg::REG_NORM_MODE:    norm_mode_r <= svn_pkg::mode_t'(cfg_ch.data[1:0]);
        svn_pkg::REG_CLIP_ENABLE:  clip_en_r   <= cfg_ch.data[0];
        svn_pkg::REG_CLAMP_ENABLE: clamp_en_r  <= cfg_ch.data[0];
        svn_pkg::REG_CLAMP_LOWER:  clamp_lo_r  <= cfg_ch.data;
        svn_pkg::REG_CLAMP_UPPER:  clamp_hi_r  <= cfg_ch.data;
        svn_pkg::REG_MASK_ENABLE:  mask_en_r   <= cfg_ch.data[0];
        svn_pkg::REG_REAL_DIM:     live_len_r  <= cfg_ch.data[8:0];
        svn_pkg::REG_PAD_VALUE:    pad_r       <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // pipeline advance
  logic out_vld_r;
  logic adv, acc;
  assign adv = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign acc = in_ch.valid && adv;

  // stats table
  logic [31:0] first_mem  [2**AW];
  logic [31:0] second_mem [2**AW];
  logic        act_mem    [2**AW];
  logic [31:0] a_rd_r, b_rd_r;
  logic        act_rd_r;
  logic [AW-1:0] adr;
  logic          idx_ok;

  assign adr    = in_ch.elem_index[AW-1:0];
  assign idx_ok = ({5'b0, in_ch.elem_index} < MAX_DIM_L);

  always_ff @(posedge clk) begin
    if (acc && idx_ok) begin
      if (in_ch.opcode == svn_pkg::OP_WRITE) begin
        first_mem[adr]  <= in_ch.first_stat;
        second_mem[adr] <= in_ch.second_stat;
        act_mem[adr]    <= in_ch.entry_active;
      end else begin
        a_rd_r   <= first_mem[adr];
        b_rd_r   <= second_mem[adr];
        act_rd_r <= act_mem[adr];
      end
    end
  end

  // stage 1: element selection
  logic               s1_vld_r, s1_ok_r;
  logic [7:0]         s1_idx_r;
  logic signed [31:0] s1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= acc && (in_ch.opcode == svn_pkg::OP_NORM);
      s1_idx_r <= in_ch.elem_index;
      s1_ok_r  <= idx_ok;
      s1_v_r   <= ({1'b0, in_ch.elem_index} < live_len_r) ? in_ch.elem_value : pad_r;
    end
  end

  // stage 2: dividend and divisor magnitudes
  logic signed [32:0] diff, dsrc;
  logic [31:0]        diff_mag, den_mag;
  svn_pkg::div_t      div_in_nxt, div_in_r, div_out;

  always_comb begin
    diff     = 33'(s1_v_r) - 33'($signed(a_rd_r));
    dsrc     = (norm_mode_r == svn_pkg::MODE_ZSCORE) ? 33'($signed(b_rd_r))
                                                     : 33'($signed(b_rd_r)) - 33'($signed(a_rd_r));
    diff_mag = diff[32] ? 32'(-diff) : diff[31:0];
    den_mag  = dsrc[32] ? 32'(-dsrc) : dsrc[31:0];
    div_in_nxt.side.vld      = s1_vld_r;
    div_in_nxt.side.idx      = s1_idx_r;
    div_in_nxt.side.v        = s1_v_r;
    div_in_nxt.side.norm     = s1_ok_r && (!mask_en_r || act_rd_r);
    div_in_nxt.side.mode     = norm_mode_r;
    div_in_nxt.side.neg      = diff[32] ^ dsrc[32];
    div_in_nxt.side.num_neg  = diff[32];
    div_in_nxt.side.num_zero = (diff == '0);
    div_in_nxt.side.den_zero = (dsrc == '0);
    div_in_nxt.q   = (norm_mode_r == svn_pkg::MODE_ZSCORE) ? svn_pkg::NUM_W'({diff_mag, 16'b0})
                                                           : svn_pkg::NUM_W'({diff_mag, 17'b0});
    div_in_nxt.rem = '0;
    div_in_nxt.den = den_mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) div_in_r.side.vld <= 1'b0;
    else if (adv) div_in_r <= div_in_nxt;
  end

  svn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .d_in  (div_in_r),
    .d_out (div_out)
  );

  // stage F1: sign, offset, saturation
  logic signed [50:0] qs;
  logic signed [31:0] f1_val_nxt, f1_val_r;
  logic               f1_err_nxt, f1_err_r, f1_vld_r, f1_clamp_r, f1_clip_r;
  logic [7:0]         f1_idx_r;
  logic               is_div;

  always_comb begin
    is_div = (div_out.side.mode == svn_pkg::MODE_ZSCORE) ||
             (div_out.side.mode == svn_pkg::MODE_MINMAX);
    qs = div_out.side.neg ? -$signed({2'b0, div_out.q}) : $signed({2'b0, div_out.q});
    if (div_out.side.mode == svn_pkg::MODE_MINMAX) qs = qs - 51'sd65536;
    f1_val_nxt = div_out.side.v;
    f1_err_nxt = 1'b0;
    if (div_out.side.norm && is_div) begin
      if (div_out.side.den_zero) begin
        f1_err_nxt = 1'b1;
        f1_val_nxt = div_out.side.num_zero ? '0 :
                     (div_out.side.num_neg ? svn_pkg::S32_MIN : svn_pkg::S32_MAX);
      end else if (qs > 51'(svn_pkg::S32_MAX)) begin
        f1_err_nxt = 1'b1;
        f1_val_nxt = svn_pkg::S32_MAX;
      end else if (qs < 51'(svn_pkg::S32_MIN)) begin
        f1_err_nxt = 1'b1;
        f1_val_nxt = svn_pkg::S32_MIN;
      end else begin
        f1_val_nxt = qs[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else if (adv) begin
      f1_vld_r   <= div_out.side.vld;
      f1_idx_r   <= div_out.side.idx;
      f1_val_r   <= f1_val_nxt;
      f1_err_r   <= f1_err_nxt;
      f1_clamp_r <= div_out.side.norm && clamp_en_r;
      f1_clip_r  <= div_out.side.norm && clip_en_r &&
                    (div_out.side.mode == svn_pkg::MODE_MINMAX);
    end
  end

  // stage F2: clip then clamp, output register
  logic signed [31:0] f2_val;
  logic [7:0]         out_idx_r;
  logic signed [31:0] out_val_r;
  logic               out_err_r;

  always_comb begin
    f2_val = f1_val_r;
    if (f1_clip_r) begin
      if (f2_val > svn_pkg::Q_ONE) f2_val = svn_pkg::Q_ONE;
      if (f2_val < svn_pkg::Q_NEG_ONE) f2_val = svn_pkg::Q_NEG_ONE;
    end
    if (f1_clamp_r) begin
      if (f2_val > clamp_hi_r) f2_val = clamp_hi_r;
      if (f2_val < clamp_lo_r) f2_val = clamp_lo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= f1_vld_r;
      out_idx_r <= f1_idx_r;
      out_val_r <= f2_val;
      out_err_r <= f1_err_r;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.out_index  = out_idx_r;
  assign out_ch.out_value  = out_val_r;
  assign out_ch.error_flag = out_err_r;

endmodule

### src/svn_chk.sv
// Port-level checks for the state vector normalizer, bound to the top level.
module svn_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_index,
  input logic [31:0] out_value,
  input logic        out_error
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(out_value)
                                && $stable(out_error))
    else $error("result changed while stalled");

  // an empty output stage never blocks requests
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request blocked with empty output");

  // a taken result frees the pipeline
  a_ready_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> in_ready)
    else $error("request blocked while result taken");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind state_vector_normalizer svn_chk u_svn_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_index (out_ch.out_index),
  .out_value (out_ch.out_value),
  .out_error (out_ch.error_flag)
);
